@@ rtl/swm_pkg.sv @@
`timescale 1ns / 1ps

package swm_pkg;

    localparam int HEIGHT_W   = 24;
    localparam int STEP_W     = 23;
    localparam int SIDE_CFG_W = 10;
    localparam int MASK_W     = 8;
    localparam int COORD_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    localparam int                        GRID_SIDE_RST     = 400;
    localparam logic [STEP_W-1:0]         STEP_STRAIGHT_RST = 23'd256;
    localparam logic [STEP_W-1:0]         STEP_DIAGONAL_RST = 23'd362;
    localparam logic signed [HEIGHT_W-1:0] BORDER_HEIGHT_RST = 24'sd256000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_SIDE     = 2'd0,
        CFG_STEP_STRAIGHT = 2'd1,
        CFG_STEP_DIAGONAL = 2'd2,
        CFG_BORDER_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_FLUSH  = 1'b1
    } req_t;

    // per-cell control carried down the pipeline with its window
    typedef struct packed {
        logic               has_out;
        logic               last;
        logic               top;
        logic               bot;
        logic               lft;
        logic               rgt;
        logic [COORD_W-1:0] crow;
        logic [COORD_W-1:0] ccol;
    } cell_meta_t;

endpackage

@@ rtl/swm_line_store.sv @@
`timescale 1ns / 1ps

module swm_line_store #(
    parameter int DEPTH = 512
) (
    input  logic                                 aclk,
    input  logic                                 rd_en,
    input  logic [$clog2(DEPTH)-1:0]             rd_addr,
    output logic [2*swm_pkg::HEIGHT_W-1:0]       rd_data,
    input  logic                                 wr_en,
    input  logic [$clog2(DEPTH)-1:0]             wr_addr,
    input  logic [2*swm_pkg::HEIGHT_W-1:0]       wr_data
);

    // entry: upper half is the row two above, lower half the row above
    logic [2*swm_pkg::HEIGHT_W-1:0] line_mem [DEPTH];
    logic [2*swm_pkg::HEIGHT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/swm_pos_div.sv @@
`timescale 1ns / 1ps

module swm_pos_div #(
    parameter int SW = 10,
    parameter int CW = 9,
    parameter int NW = 19
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [SW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [NW-1:0] quo,
    output logic [CW-1:0] rem
);

    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [SW:0]     rem_reg, rem_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [SW-1:0]   div_reg;
    logic [SW:0]     rem_sh;
    logic            ge;

    // restoring division, one quotient bit a cycle
    assign rem_sh = {rem_reg[SW-1:0], quo_reg[NW-1]};
    assign ge     = rem_sh >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(NW);
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = ge ? (rem_sh - {1'b0, div_reg}) : rem_sh;
            quo_next = {quo_reg[NW-2:0], ge};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            div_reg <= divisor;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg[CW-1:0];

endmodule

@@ rtl/swm_window.sv @@
`timescale 1ns / 1ps

module swm_window (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               shift_en,
    input  logic signed [swm_pkg::HEIGHT_W-1:0] up2,
    input  logic signed [swm_pkg::HEIGHT_W-1:0] up1,
    input  logic signed [swm_pkg::HEIGHT_W-1:0] cur,
    input  swm_pkg::cell_meta_t                meta,
    input  logic [swm_pkg::STEP_W-1:0]         step_straight,
    input  logic [swm_pkg::STEP_W-1:0]         step_diagonal,
    output logic [swm_pkg::MASK_W-1:0]         walk_mask
);

    localparam int HW = swm_pkg::HEIGHT_W;

    // 3x3 window, index row*3+col, column 2 is the newest
    logic signed [HW-1:0] win_reg [9];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (shift_en) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r*3]   <= win_reg[r*3+1];
                win_reg[r*3+1] <= win_reg[r*3+2];
            end
            win_reg[2] <= up2;
            win_reg[5] <= up1;
            win_reg[8] <= cur;
        end
    end

    genvar b;
    for (b = 0; b < swm_pkg::MASK_W; b++) begin : g_nb
        localparam int K  = (b < 4) ? b : b + 1;
        localparam int DR = K / 3;
        localparam int DC = K % 3;
        localparam bit DIAG = (DR != 1) && (DC != 1);

        logic signed [HW:0] diff;
        logic [HW:0]        mag;
        logic [HW:0]        limit;
        logic               inb;

        assign diff  = {win_reg[K][HW-1], win_reg[K]} - {win_reg[4][HW-1], win_reg[4]};
        assign mag   = diff[HW] ? $unsigned(-diff) : $unsigned(diff);
        assign limit = {2'b00, (DIAG ? step_diagonal : step_straight)};
        assign inb   = !((DR == 0) && meta.top) && !((DR == 2) && meta.bot)
                    && !((DC == 0) && meta.lft) && !((DC == 2) && meta.rgt);
        assign walk_mask[b] = inb && (mag < limit);
    end

endmodule

@@ rtl/slope_walkability_mask_core.sv @@
`timescale 1ns / 1ps

// slope walkability mask core
//
// s_ channel: one transfer per grid cell in raster order, height in s_tdata,
// s_tuser selects sample or flush. after the grid, grid_side+1 flush transfers
// drain the remaining masks. m_ channel: one mask per cell in raster order,
// m_tlast marks the final cell of the grid.
// config port: cfg_we/cfg_addr/cfg_wdata, written while the core is idle.
// throughput: one input transfer per cycle unless a stalled output or a divider run holds
// the input; one line store read-modify-write per item (read at accept, write as it moves on)
// sets this rate. m_tvalid rises once the transfer that completes a cell's 3x3 window has
// passed stage 1, the window stage and the output register; the cell is one row plus one item before it.
// a grid_side write re-derives the raster position with a bit-serial divider;
// s_tready stays low until the divider is done.
// reset: counters, window and output clear, no line store clearing is needed.
// when m_tready is low the output register holds its mask; the two internal
// stages still fill, then s_tready drops until the mask is taken.

module slope_walkability_mask_core #(
    parameter int MAX_SIDE = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    // fields from bit 0: height[23:0]
    input  logic [swm_pkg::IN_DATA_W-1:0]  s_tdata,
    // fields from bit 0: req_type[0]
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // fields from bit 0: walk_mask[7:0], cell_row[16:8], cell_col[25:17], zero pad
    output logic [swm_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_we,
    input  logic [swm_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [swm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int HW  = swm_pkg::HEIGHT_W;
    localparam int SW  = $clog2(MAX_SIDE + 1);
    localparam int CW  = $clog2(MAX_SIDE);
    localparam int NW  = $clog2(MAX_SIDE * MAX_SIDE + MAX_SIDE + 1);
    localparam int GXW = (SW > swm_pkg::SIDE_CFG_W) ? SW : swm_pkg::SIDE_CFG_W;
    localparam int SIDE_RST = (swm_pkg::GRID_SIDE_RST > MAX_SIDE) ?
                              MAX_SIDE : swm_pkg::GRID_SIDE_RST;

    // configuration
    logic [SW-1:0]                 s_reg, sm1_reg;
    logic [swm_pkg::STEP_W-1:0]    step_str_reg, step_dia_reg;
    logic signed [HW-1:0]          border_reg;
    logic [GXW-1:0]                gs_x;
    logic [SW-1:0]                 s_new;
    logic                          side_wr;

    // raster position of the next item
    logic [SW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [NW-1:0] n_reg, n_next;

    // pipeline
    logic                  valid1_reg, valid1_next;
    logic                  valid2_reg, valid2_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic signed [HW-1:0]  v1_reg;
    logic [CW-1:0]         col1_reg;
    swm_pkg::cell_meta_t   meta1_reg, meta2_reg, meta0;
    logic [swm_pkg::MASK_W-1:0]  mask_reg;
    logic [swm_pkg::COORD_W-1:0] crow_o_reg, ccol_o_reg;
    logic                  last_o_reg;

    logic free_out, leave2, out_load, adv2, acc;
    logic at_end, col_last, is_sample, on_border;
    logic [SW-1:0] crow0, ccol0;
    logic signed [HW-1:0] v0;
    logic [2*HW-1:0] rd_data;
    logic [2*HW-1:0] rd_word, wr_word;
    logic            fwd_hit_reg;
    logic [2*HW-1:0] fwd_data_reg;
    logic [swm_pkg::MASK_W-1:0] walk_mask;

    logic          div_busy, div_done, div_wrap;
    logic [NW-1:0] div_quo;
    logic [CW-1:0] div_rem;

    // ---------------- configuration ----------------
    assign gs_x = GXW'(cfg_wdata[swm_pkg::SIDE_CFG_W-1:0]);
    always_comb begin
        if (gs_x < GXW'(3)) begin
            s_new = SW'(3);
        end else if (gs_x > GXW'(MAX_SIDE)) begin
            s_new = SW'(MAX_SIDE);
        end else begin
            s_new = SW'(gs_x);
        end
    end

    assign side_wr = cfg_we && (cfg_addr == swm_pkg::CFG_GRID_SIDE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_reg        <= SW'(SIDE_RST);
            sm1_reg      <= SW'(SIDE_RST - 1);
            step_str_reg <= swm_pkg::STEP_STRAIGHT_RST;
            step_dia_reg <= swm_pkg::STEP_DIAGONAL_RST;
            border_reg   <= swm_pkg::BORDER_HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                swm_pkg::CFG_GRID_SIDE: begin
                    s_reg   <= s_new;
                    sm1_reg <= s_new - SW'(1);
                end
                swm_pkg::CFG_STEP_STRAIGHT: begin
                    step_str_reg <= cfg_wdata[swm_pkg::STEP_W-1:0];
                end
                swm_pkg::CFG_STEP_DIAGONAL: begin
                    step_dia_reg <= cfg_wdata[swm_pkg::STEP_W-1:0];
                end
                swm_pkg::CFG_BORDER_HEIGHT: begin
                    border_reg <= $signed(cfg_wdata[HW-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // re-derive row and column of the item count under a new side
    swm_pos_div #(
        .SW (SW),
        .CW (CW),
        .NW (NW)
    ) u_pos_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (side_wr),
        .dividend (n_reg),
        .divisor  (s_new),
        .busy     (div_busy),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    // count past the end of the grid plus drain restarts it
    assign div_wrap = (div_quo > NW'(s_reg) + NW'(1)) ||
                      ((div_quo == NW'(s_reg) + NW'(1)) && (div_rem != '0));

    // ---------------- stage 0: accept ----------------
    assign free_out = !m_tvalid_reg || m_tready;
    assign leave2   = valid2_reg && (!meta2_reg.has_out || free_out);
    assign out_load = valid2_reg && meta2_reg.has_out && free_out;
    assign adv2     = valid1_reg && (!valid2_reg || leave2);
    assign s_tready = (!valid1_reg || adv2) && !div_busy && !div_done;
    assign acc      = s_tvalid && s_tready;

    // final drain item sits at row grid_side+1, column 0
    assign at_end    = (row_reg == s_reg + SW'(1)) && (col_reg == '0);
    assign col_last  = (SW'(col_reg) == sm1_reg);
    assign is_sample = (s_tuser == swm_pkg::REQ_SAMPLE) && (row_reg < s_reg);
    assign on_border = (row_reg == '0) || (row_reg == sm1_reg) ||
                       (col_reg == '0) || col_last;
    assign v0 = (!is_sample || on_border) ? border_reg : $signed(s_tdata[HW-1:0]);

    // mask cell lags by one row plus one item
    always_comb begin
        if (col_reg == '0) begin
            crow0 = row_reg - SW'(2);
            ccol0 = sm1_reg;
        end else begin
            crow0 = row_reg - SW'(1);
            ccol0 = SW'(col_reg) - SW'(1);
        end
        meta0.has_out = (row_reg >= SW'(2)) || ((row_reg == SW'(1)) && (col_reg != '0));
        meta0.last    = at_end;
        meta0.top     = (crow0 == '0);
        meta0.bot     = (crow0 == sm1_reg);
        meta0.lft     = (ccol0 == '0);
        meta0.rgt     = (ccol0 == sm1_reg);
        meta0.crow    = swm_pkg::COORD_W'(crow0);
        meta0.ccol    = swm_pkg::COORD_W'(ccol0);
    end

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        n_next   = n_reg;
        if (div_done) begin
            if (div_wrap) begin
                row_next = '0;
                col_next = '0;
                n_next   = '0;
            end else begin
                row_next = SW'(div_quo);
                col_next = div_rem;
            end
        end else if (acc) begin
            if (at_end) begin
                row_next = '0;
                col_next = '0;
                n_next   = '0;
            end else begin
                n_next = n_reg + NW'(1);
                if (col_last) begin
                    col_next = '0;
                    row_next = row_reg + SW'(1);
                end else begin
                    col_next = col_reg + CW'(1);
                end
            end
        end
    end

    always_comb begin
        valid1_next = acc ? 1'b1 : (adv2 ? 1'b0 : valid1_reg);
        valid2_next = adv2 ? 1'b1 : (leave2 ? 1'b0 : valid2_reg);
        m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            n_reg        <= '0;
            valid1_reg   <= 1'b0;
            valid2_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            n_reg        <= n_next;
            valid1_reg   <= valid1_next;
            valid2_reg   <= valid2_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            v1_reg       <= v0;
            col1_reg     <= col_reg;
            meta1_reg    <= meta0;
            fwd_hit_reg  <= adv2 && (col1_reg == col_reg);
            fwd_data_reg <= wr_word;
        end
        if (adv2) begin
            meta2_reg <= meta1_reg;
        end
        if (out_load) begin
            mask_reg   <= walk_mask;
            crow_o_reg <= meta2_reg.crow;
            ccol_o_reg <= meta2_reg.ccol;
            last_o_reg <= meta2_reg.last;
        end
    end

    // ---------------- stage 1: line store read-modify-write ----------------
    // read at accept, write back when the item moves on; consecutive items
    // share a column only across the grid wrap, there the written word is forwarded
    assign rd_word = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign wr_word = {rd_word[HW-1:0], v1_reg};

    swm_line_store #(
        .DEPTH (MAX_SIDE)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (acc),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (adv2),
        .wr_addr (col1_reg),
        .wr_data (wr_word)
    );

    // ---------------- stage 2: window and mask ----------------
    swm_window u_window (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .shift_en      (adv2),
        .up2           ($signed(rd_word[2*HW-1:HW])),
        .up1           ($signed(rd_word[HW-1:0])),
        .cur           (v1_reg),
        .meta          (meta2_reg),
        .step_straight (step_str_reg),
        .step_diagonal (step_dia_reg),
        .walk_mask     (walk_mask)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_o_reg;
    assign m_tdata  = {{(swm_pkg::OUT_DATA_W - swm_pkg::MASK_W - 2*swm_pkg::COORD_W){1'b0}},
                       ccol_o_reg, crow_o_reg, mask_reg};

`ifndef SYNTHESIS
    a_same_col_at_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv2 && acc && (col1_reg == col_reg)) |-> (col_reg == '0))
        else $error("line store read and write hit the same column inside a grid");

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (!div_busy && !div_done) |->
            ((row_reg <= s_reg) || ((row_reg == s_reg + SW'(1)) && (col_reg == '0))))
        else $error("raster position outside grid plus drain");

    a_end_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && at_end) |=> ((row_reg == '0) && (col_reg == '0) && (n_reg == '0)))
        else $error("grid end did not restart the count");

    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> ((m_tdata[7:4] == 4'b0000) && !m_tdata[2]))
        else $error("final cell marks a neighbour outside the grid");
`endif

endmodule

@@ bench/slope_walkability_mask_core_test.sv @@
`timescale 1ns / 1ps

module slope_walkability_mask_core_test;

    localparam int MAX_SIDE     = 512;
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 30;
    localparam int STEP_MAX     = 8388607;
    localparam int HW           = swm_pkg::HEIGHT_W;
    localparam int STW          = swm_pkg::STEP_W;
    localparam int CDW          = swm_pkg::CFG_DATA_W;

    typedef struct packed {
        logic [swm_pkg::MASK_W-1:0]  walk;
        logic [swm_pkg::COORD_W-1:0] row;
        logic [swm_pkg::COORD_W-1:0] col;
        logic                        fin;
    } mask_result_t;

    class mask_scoreboard;
        int side_raw;
        int straight_lim;
        int diag_lim;
        int border_h;
        int line_store[2*MAX_SIDE];
        int win[9];
        int pos;
        int errors;
        mask_result_t masks_q[$];

        function new();
            side_raw     = swm_pkg::GRID_SIDE_RST;
            straight_lim = int'(swm_pkg::STEP_STRAIGHT_RST);
            diag_lim     = int'(swm_pkg::STEP_DIAGONAL_RST);
            border_h     = swm_pkg::BORDER_HEIGHT_RST;
            pos          = 0;
            errors       = 0;
            foreach (line_store[i]) line_store[i] = 0;
            foreach (win[i]) win[i] = 0;
        endfunction

        function int eff_side();
            if (side_raw < 3) return 3;
            if (side_raw > MAX_SIDE) return MAX_SIDE;
            return side_raw;
        endfunction

        function int pending();
            return masks_q.size();
        endfunction

        function void write_reg(swm_pkg::cfg_idx_t idx, logic [CDW-1:0] val);
            case (idx)
                swm_pkg::CFG_GRID_SIDE:     side_raw = int'(val[swm_pkg::SIDE_CFG_W-1:0]);
                swm_pkg::CFG_STEP_STRAIGHT: straight_lim = int'(val[STW-1:0]);
                swm_pkg::CFG_STEP_DIAGONAL: diag_lim = int'(val[STW-1:0]);
                swm_pkg::CFG_BORDER_HEIGHT: border_h = $signed(val);
                default: ;
            endcase
        endfunction

        function void flag(string msg);
            errors++;
            $display("%s", msg);
        endfunction

        // advance the window by one transfer and queue the mask it completes
        function void note_input(swm_pkg::req_t kind, logic [HW-1:0] h);
            int s, cells_n, total, n, r, c, v, up1, up2;
            int cidx, crow, ccol, centre, nr, nc, diff, mag, lim, bitn;
            mask_result_t res;
            s       = eff_side();
            cells_n = s * s;
            total   = cells_n + s + 1;
            n       = (pos >= total) ? 0 : pos;
            r       = n / s;
            c       = n % s;
            if (kind != swm_pkg::REQ_SAMPLE || n >= cells_n || r == 0 || r == s - 1
                || c == 0 || c == s - 1) begin
                v = border_h;
            end else begin
                v = $signed(h);
            end
            up1 = line_store[c];
            up2 = line_store[MAX_SIDE + c];
            for (int k = 0; k < 3; k++) begin
                win[k*3]     = win[k*3 + 1];
                win[k*3 + 1] = win[k*3 + 2];
            end
            win[2] = up2;
            win[5] = up1;
            win[8] = v;
            line_store[MAX_SIDE + c] = up1;
            line_store[c] = v;
            pos = (n + 1 >= total) ? 0 : n + 1;
            if (n < s + 1) return;

            cidx   = n - s - 1;
            crow   = cidx / s;
            ccol   = cidx % s;
            centre = win[4];
            bitn   = 0;
            res    = '0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    if (dr != 0 || dc != 0) begin
                        nr = crow + dr;
                        nc = ccol + dc;
                        if (nr >= 0 && nc >= 0 && nr < s && nc < s) begin
                            diff = win[(dr + 1) * 3 + dc + 1] - centre;
                            mag  = (diff < 0) ? -diff : diff;
                            lim  = (dr == 0 || dc == 0) ? straight_lim : diag_lim;
                            if (mag < lim) res.walk[bitn] = 1'b1;
                        end
                        bitn++;
                    end
                end
            end
            res.row = crow[swm_pkg::COORD_W-1:0];
            res.col = ccol[swm_pkg::COORD_W-1:0];
            res.fin = (cidx == cells_n - 1);
            masks_q = {masks_q, res};
        endfunction

        function void check_result(logic [swm_pkg::OUT_DATA_W-1:0] data, logic fin);
            mask_result_t exp_r;
            if (masks_q.size() == 0) begin
                flag($sformatf("%0t: mask transfer with nothing expected, actual data %h last %b",
                    $time, data, fin));
                return;
            end
            exp_r = masks_q.pop_front();
            if (data[7:0] != exp_r.walk)
                flag($sformatf("%0t: walk_mask expected %h actual %h", $time, exp_r.walk,
                    data[7:0]));
            if (data[16:8] != exp_r.row)
                flag($sformatf("%0t: cell_row expected %0d actual %0d", $time, exp_r.row,
                    data[16:8]));
            if (data[25:17] != exp_r.col)
                flag($sformatf("%0t: cell_col expected %0d actual %0d", $time, exp_r.col,
                    data[25:17]));
            if (fin !== exp_r.fin)
                flag($sformatf("%0t: last expected %b actual %b", $time, exp_r.fin, fin));
            if (data[swm_pkg::OUT_DATA_W-1:26] != '0)
                flag($sformatf("%0t: tdata pad expected 0 actual %h", $time,
                    data[swm_pkg::OUT_DATA_W-1:26]));
        endfunction
    endclass

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic [swm_pkg::IN_DATA_W-1:0]    s_tdata   = '0;
    logic                             s_tuser   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [swm_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic                             m_tlast;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [swm_pkg::CFG_IDX_W-1:0]    cfg_addr  = '0;
    logic [CDW-1:0]                   cfg_wdata = '0;

    mask_scoreboard sb = new();
    int  burst_left   = 0;
    int  items_sent   = 0;
    int  stall_cycles = 0;
    int  rx_cyc       = 0;
    bit  held_once    = 1'b0;

    slope_walkability_mask_core #(
        .MAX_SIDE(MAX_SIDE)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // receiver cycles through always ready, mostly ready, mostly stalled, periodic
    always @(negedge aclk) begin
        rx_cyc <= rx_cyc + 1;
        case ((rx_cyc / 128) % 4)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((rx_cyc % 9) < 4);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic send_item(input swm_pkg::req_t kind, input logic [HW-1:0] h);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= h;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_input(kind, h);
        items_sent++;
    endtask

    // hold the sender until every mask is out, then let the pipeline go quiet
    task automatic settle(input int extra);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_reg(input swm_pkg::cfg_idx_t idx, input logic [CDW-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // one full grid plus its drain; a broken grid swaps sample and flush at random
    task automatic send_grid(input int base, input int spread, input bit broken);
        int s;
        swm_pkg::req_t kind;
        logic [HW-1:0] h;
        s = sb.eff_side();
        for (int i = 0; i < s * s + s + 1; i++) begin
            kind = (i < s * s) ? swm_pkg::REQ_SAMPLE : swm_pkg::REQ_FLUSH;
            if (broken && $urandom_range(0, 4) == 0)
                kind = (kind == swm_pkg::REQ_SAMPLE) ? swm_pkg::REQ_FLUSH
                                                     : swm_pkg::REQ_SAMPLE;
            if ($urandom_range(0, 15) == 0) h = HW'($urandom());
            else h = HW'(base + int'($urandom_range(0, 2 * spread)) - spread);
            if ((!held_once && i == s * s / 2) || $urandom_range(0, 299) == 0) begin
                settle(0);
                held_once = 1'b1;
            end
            send_item(kind, h);
        end
    endtask

    function automatic int pick_step(input int spread);
        case ($urandom_range(0, 7))
            0:       return 1;
            1:       return STEP_MAX;
            default: return $urandom_range(1, 2 * spread + 2);
        endcase
    endfunction

    initial begin
        int rand_start, pick, side_w, spread, base;
        logic [CDW-1:0] w;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // side 0 acts as 3; inner cell 100 above the lowest border
        write_reg(swm_pkg::CFG_GRID_SIDE, 24'h000000);
        write_reg(swm_pkg::CFG_STEP_STRAIGHT, 24'h7FFFFF);
        write_reg(swm_pkg::CFG_STEP_DIAGONAL, 24'h000001);
        write_reg(swm_pkg::CFG_BORDER_HEIGHT, 24'h800000);
        for (int i = 0; i < 13; i++) begin
            if (i == 4) send_item(swm_pkg::REQ_SAMPLE, 24'h800064);
            else if (i < 9)
                send_item(swm_pkg::REQ_SAMPLE, (i % 2) ? 24'h7FFFFF : 24'h000000);
            else send_item((i % 2) ? swm_pkg::REQ_SAMPLE : swm_pkg::REQ_FLUSH, 24'hFFFFFF);
        end

        // side 2 acts as 3, upper bits of the writes are dropped; flush on the inner
        // cell and samples during the drain
        settle(12);
        write_reg(swm_pkg::CFG_GRID_SIDE, 24'hFFFC02);
        write_reg(swm_pkg::CFG_STEP_STRAIGHT, 24'h800001);
        write_reg(swm_pkg::CFG_STEP_DIAGONAL, 24'hFFFFFF);
        write_reg(swm_pkg::CFG_BORDER_HEIGHT, 24'h7FFFFF);
        for (int i = 0; i < 13; i++)
            send_item((i == 4) ? swm_pkg::REQ_FLUSH : swm_pkg::REQ_SAMPLE, HW'($urandom()));

        // side 1023 acts as the maximum; just past one row in, then a smaller side
        // leaves the count past the end of the grid
        settle(12);
        write_reg(swm_pkg::CFG_GRID_SIDE, 24'hABC3FF);
        write_reg(swm_pkg::CFG_STEP_STRAIGHT, 24'd300);
        write_reg(swm_pkg::CFG_STEP_DIAGONAL, 24'd420);
        write_reg(swm_pkg::CFG_BORDER_HEIGHT, 24'h001000);
        for (int i = 0; i < 520; i++)
            send_item(swm_pkg::REQ_SAMPLE, HW'(24'h001000 + $urandom_range(0, 700) - 350));

        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            settle(12);
            pick = $urandom_range(0, 9);
            if (pick == 0) side_w = $urandom_range(0, 2);
            else if (pick == 1) side_w = $urandom_range(9, 12);
            else side_w = $urandom_range(3, 8);
            spread = $urandom_range(1, 1 << $urandom_range(1, 14));
            base   = int'($urandom());

            w = CDW'($urandom());
            w[swm_pkg::SIDE_CFG_W-1:0] = side_w[swm_pkg::SIDE_CFG_W-1:0];
            write_reg(swm_pkg::CFG_GRID_SIDE, w);
            w = CDW'($urandom());
            w[STW-1:0] = STW'(pick_step(spread));
            write_reg(swm_pkg::CFG_STEP_STRAIGHT, w);
            w = CDW'($urandom());
            w[STW-1:0] = STW'(pick_step(spread));
            write_reg(swm_pkg::CFG_STEP_DIAGONAL, w);
            if ($urandom_range(0, 3) == 0) w = CDW'($urandom());
            else w = CDW'(base + int'($urandom_range(0, 2 * spread)) - spread);
            write_reg(swm_pkg::CFG_BORDER_HEIGHT, w);

            repeat ($urandom_range(1, 3)) send_grid(base, spread, $urandom_range(0, 3) == 0);
        end

        settle(20);
        if (sb.errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/swm_pkg.sv
rtl/swm_line_store.sv
rtl/swm_pos_div.sv
rtl/swm_window.sv
rtl/slope_walkability_mask_core.sv
bench/slope_walkability_mask_core_test.sv
